// ===== rtl/core/sd_spi_host_sequencer_core_macros.svh =====
// Assertion macros used by the checker file of the SD SPI sequencer.
`ifndef SD_SPI_HOST_SEQUENCER_CORE_MACROS_SVH
`define SD_SPI_HOST_SEQUENCER_CORE_MACROS_SVH
`define SDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/sds_pkg.sv =====
// Package with the phase type, command codes and item types of the SD SPI sequencer.
package sds_pkg;
    typedef enum logic [3:0] {
        PH_IDLE, PH_WAKE, PH_CMD, PH_R1, PH_TAIL, PH_TOKEN, PH_DATA, PH_CRC, PH_BUSY
    } t_phase;

    localparam logic [5:0] CMD_GO_IDLE = 6'd0;
    localparam logic [5:0] CMD_IF_COND = 6'd8;
    localparam logic [5:0] CMD_STOP = 6'd12;
    localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
    localparam logic [5:0] CMD_READ_ONE = 6'd17;
    localparam logic [5:0] CMD_READ_MULTI = 6'd18;
    localparam logic [5:0] CMD_OP_COND = 6'd41;
    localparam logic [5:0] CMD_APP = 6'd55;
    localparam logic [5:0] CMD_READ_OCR = 6'd58;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_INIT = 2'd1;
    localparam logic [1:0] KIND_READ_ONE = 2'd2;
    localparam logic [1:0] KIND_READ_MULTI = 2'd3;

    localparam logic [3:0] ST_OK = 4'd0;
    localparam logic [3:0] ST_CMD0 = 4'd1;
    localparam logic [3:0] ST_CMD8 = 4'd2;
    localparam logic [3:0] ST_ECHO = 4'd3;
    localparam logic [3:0] ST_ACMD41 = 4'd4;
    localparam logic [3:0] ST_CMD58 = 4'd5;
    localparam logic [3:0] ST_CMD16 = 4'd6;
    localparam logic [3:0] ST_READ = 4'd7;
    localparam logic [3:0] ST_TOKEN = 4'd8;

    localparam logic [0:0] CFG_TOKEN_LIMIT = 1'd0;
    localparam logic [0:0] CFG_RETRY_LIMIT = 1'd1;

    localparam logic [7:0] BYTE_IDLE = 8'hFF;
    localparam logic [7:0] DATA_TOKEN = 8'hFE;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  miso_byte;
        logic [31:0] block_address;
        logic [7:0]  block_count;
    } t_in_item;

    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       select_low;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       block_end;
        logic       done_res;
        logic [3:0] status;
    } t_out_item;
endpackage

// ===== rtl/core/sds_stream_if.sv =====
// Valid/ready channel interface carrying one payload.
interface sds_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sds_engine.sv =====
// Combinational next-state and result logic for one byte exchange.
module sds_engine #(
    parameter int BLOCK_BYTES = 512,
    parameter int RESPONSE_WAIT = 8
) (
    input  sds_pkg::t_in_item  i_item,
    input  sds_pkg::t_phase    i_phase,
    input  logic [15:0]        i_cnt,
    input  logic [15:0]        i_retry,
    input  logic [47:0]        i_frame,
    input  logic [31:0]        i_cap,
    input  logic               i_hc,
    input  logic [7:0]         i_blocks,
    input  logic [15:0]        i_tok_lim,
    input  logic [15:0]        i_ret_lim,
    output sds_pkg::t_phase    o_phase,
    output logic [15:0]        o_cnt,
    output logic [15:0]        o_retry,
    output logic [47:0]        o_frame,
    output logic [31:0]        o_cap,
    output logic               o_hc,
    output logic [7:0]         o_blocks,
    output sds_pkg::t_out_item o_res
);
    import sds_pkg::*;

    localparam logic [15:0] WAKE_BYTES = 16'd11;
    localparam logic [15:0] RW = 16'(RESPONSE_WAIT);
    localparam logic [15:0] BB = 16'(BLOCK_BYTES);
    localparam int SHIFT = $clog2(BLOCK_BYTES);

    function automatic logic [47:0] frame(input logic [5:0] c, input logic [31:0] a,
                                          input logic [7:0] crc);
        frame = {2'b01, c, a, crc};
    endfunction

    logic [5:0]  cmd;
    logic [15:0] inc;
    logic [7:0]  miso;
    logic [31:0] addr;
    logic [3:0]  p;
    logic [7:0]  r;
    logic [31:0] cap_next;

    assign cmd = i_frame[45:40];
    assign inc = i_cnt + 16'd1;
    assign miso = i_item.miso_byte;
    assign addr = i_hc ? i_item.block_address : (i_item.block_address << SHIFT);
    assign p = (i_cnt > 16'd8) ? 4'd8 : i_cnt[3:0];
    assign r = (miso != BYTE_IDLE) ? miso : BYTE_IDLE;
    assign cap_next = {i_cap[23:0], miso};

    always_comb begin
        o_phase = i_phase;
        o_cnt = i_cnt;
        o_retry = i_retry;
        o_frame = i_frame;
        o_cap = i_cap;
        o_hc = i_hc;
        o_blocks = i_blocks;
        o_res = '0;
        o_res.mosi_byte = BYTE_IDLE;
        case (i_phase)
            PH_WAKE: begin
                if (inc >= WAKE_BYTES) begin
                    o_frame = frame(CMD_GO_IDLE, 32'd0, 8'h95);
                    o_phase = PH_CMD;
                    o_cnt = 16'd2;
                end else begin
                    o_cnt = inc;
                end
            end
            PH_CMD: begin
                o_res.select_low = 1'b1;
                if (p >= 4'd3) o_res.mosi_byte = i_frame[8*(8-p) +: 8];
                if (p >= 4'd8) begin
                    o_phase = PH_R1;
                    o_cnt = 16'd0;
                end else begin
                    o_cnt = {12'd0, p} + 16'd1;
                end
            end
            PH_R1: begin
                if (i_cnt == 16'd0) begin
                    o_res.select_low = 1'b1;
                    o_cnt = 16'd1;
                end else if (miso == BYTE_IDLE && i_cnt < RW) begin
                    o_res.select_low = 1'b1;
                    o_cnt = inc;
                end else begin
                    o_res.select_low = 1'b1;
                    case (cmd)
                        CMD_GO_IDLE: begin
                            if (r == 8'h01) begin
                                o_frame = frame(CMD_IF_COND, 32'h1AA, 8'h87);
                                o_phase = PH_CMD;
                                o_cnt = 16'd3;
                            end else begin
                                o_res.select_low = 1'b0;
                                o_res.done_res = 1'b1;
                                o_res.status = ST_CMD0;
                                o_phase = PH_IDLE;
                            end
                        end
                        CMD_IF_COND, CMD_READ_OCR: begin
                            if (r == ((cmd == CMD_IF_COND) ? 8'h01 : 8'h00)) begin
                                o_cap = '0;
                                o_phase = PH_TAIL;
                                o_cnt = 16'd0;
                            end else begin
                                o_res.select_low = 1'b0;
                                o_res.done_res = 1'b1;
                                o_res.status = (cmd == CMD_IF_COND) ? ST_CMD8 : ST_CMD58;
                                o_phase = PH_IDLE;
                            end
                        end
                        CMD_APP: begin
                            o_frame = frame(CMD_OP_COND, 32'h40000000, 8'h01);
                            o_phase = PH_CMD;
                            o_cnt = 16'd1;
                        end
                        CMD_OP_COND: begin
                            if (r == 8'h01 && i_retry < i_ret_lim) begin
                                o_res.select_low = 1'b0;
                                o_retry = i_retry + 16'd1;
                                o_frame = frame(CMD_APP, 32'd0, 8'h65);
                                o_phase = PH_CMD;
                                o_cnt = 16'd2;
                            end else if (r == 8'h00) begin
                                o_frame = frame(CMD_READ_OCR, 32'd0, 8'h01);
                                o_phase = PH_CMD;
                                o_cnt = 16'd3;
                            end else begin
                                o_res.select_low = 1'b0;
                                o_res.done_res = 1'b1;
                                o_res.status = ST_ACMD41;
                                o_phase = PH_IDLE;
                            end
                        end
                        CMD_READ_ONE, CMD_READ_MULTI: begin
                            if (r != 8'h00) begin
                                o_res.select_low = 1'b0;
                                o_res.done_res = 1'b1;
                                o_res.status = ST_READ;
                                o_phase = PH_IDLE;
                            end else if (cmd == CMD_READ_MULTI && i_blocks == 8'd0) begin
                                o_cap = '0;
                                o_frame = frame(CMD_STOP, 32'd0, 8'h01);
                                o_phase = PH_CMD;
                                o_cnt = 16'd3;
                            end else begin
                                o_phase = PH_TOKEN;
                                o_cnt = 16'd0;
                            end
                        end
                        CMD_STOP: begin
                            o_phase = PH_BUSY;
                            o_cnt = 16'd0;
                        end
                        default: begin
                            o_res.select_low = 1'b0;
                            o_res.done_res = 1'b1;
                            o_res.status = (cmd == CMD_BLOCKLEN && r != 8'h00) ?
                                           ST_CMD16 : ST_OK;
                            o_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            PH_TAIL: begin
                o_cap = cap_next;
                o_cnt = inc;
                o_res.select_low = 1'b1;
                if (inc >= 16'd4) begin
                    if (cmd == CMD_IF_COND) begin
                        if (cap_next[15:0] == 16'h01AA && i_retry < i_ret_lim) begin
                            o_res.select_low = 1'b0;
                            o_retry = i_retry + 16'd1;
                            o_frame = frame(CMD_APP, 32'd0, 8'h65);
                            o_phase = PH_CMD;
                            o_cnt = 16'd2;
                        end else begin
                            o_res.select_low = 1'b0;
                            o_res.done_res = 1'b1;
                            o_res.status = (cap_next[15:0] == 16'h01AA) ? ST_ACMD41 : ST_ECHO;
                            o_phase = PH_IDLE;
                        end
                    end else begin
                        o_hc = cap_next[30];
                        o_res.select_low = 1'b0;
                        if (cap_next[30]) begin
                            o_res.done_res = 1'b1;
                            o_res.status = ST_OK;
                            o_phase = PH_IDLE;
                        end else begin
                            o_frame = frame(CMD_BLOCKLEN, 32'(BLOCK_BYTES), 8'h01);
                            o_phase = PH_CMD;
                            o_cnt = 16'd2;
                        end
                    end
                end
            end
            PH_TOKEN: begin
                o_res.select_low = 1'b1;
                if (miso == DATA_TOKEN) begin
                    o_phase = PH_DATA;
                    o_cnt = 16'd0;
                end else if ({1'b0, i_cnt} + 17'd1 >= {1'b0, i_tok_lim}) begin
                    if (cmd == CMD_READ_MULTI) begin
                        o_cap = 32'(ST_TOKEN);
                        o_frame = frame(CMD_STOP, 32'd0, 8'h01);
                        o_phase = PH_CMD;
                        o_cnt = 16'd3;
                    end else begin
                        o_res.select_low = 1'b0;
                        o_res.done_res = 1'b1;
                        o_res.status = ST_TOKEN;
                        o_phase = PH_IDLE;
                    end
                end else begin
                    o_cnt = inc;
                end
            end
            PH_DATA: begin
                o_res.select_low = 1'b1;
                o_res.data_valid = 1'b1;
                o_res.data_byte = miso;
                if (inc >= BB) begin
                    o_res.block_end = 1'b1;
                    o_phase = PH_CRC;
                    o_cnt = 16'd0;
                end else begin
                    o_cnt = inc;
                end
            end
            PH_CRC: begin
                o_res.select_low = 1'b1;
                if (inc < 16'd2) begin
                    o_cnt = inc;
                end else if (cmd == CMD_READ_MULTI) begin
                    o_blocks = (i_blocks > 8'd0) ? i_blocks - 8'd1 : 8'd0;
                    if (i_blocks > 8'd1) begin
                        o_phase = PH_TOKEN;
                        o_cnt = 16'd0;
                    end else begin
                        o_cap = '0;
                        o_frame = frame(CMD_STOP, 32'd0, 8'h01);
                        o_phase = PH_CMD;
                        o_cnt = 16'd3;
                    end
                end else begin
                    o_res.select_low = 1'b0;
                    o_res.done_res = 1'b1;
                    o_res.status = ST_OK;
                    o_phase = PH_IDLE;
                end
            end
            PH_BUSY: begin
                if (miso == BYTE_IDLE || {1'b0, i_cnt} + 17'd1 >= {1'b0, i_tok_lim}) begin
                    o_res.done_res = 1'b1;
                    o_res.status = i_cap[3:0];
                    o_phase = PH_IDLE;
                end else begin
                    o_res.select_low = 1'b1;
                    o_cnt = inc;
                end
            end
            default: begin
                o_phase = PH_IDLE;
                case (i_item.kind)
                    KIND_INIT: begin
                        o_retry = '0;
                        o_phase = PH_WAKE;
                        o_cnt = 16'd1;
                    end
                    KIND_READ_ONE, KIND_READ_MULTI: begin
                        if (i_item.kind == KIND_READ_MULTI) begin
                            o_blocks = i_item.block_count;
                            o_frame = frame(CMD_READ_MULTI, addr, 8'h01);
                        end else begin
                            o_frame = frame(CMD_READ_ONE, addr, 8'h01);
                        end
                        o_res.select_low = 1'b1;
                        o_phase = PH_CMD;
                        o_cnt = 16'd3;
                    end
                    default: ;
                endcase
            end
        endcase
    end
endmodule

// ===== rtl/core/sd_spi_host_sequencer_core.sv =====
// Top level of the SD SPI-mode host sequencer.
// Channel  | Direction | Payload
// s_in     | sink      | kind, miso_byte, block_address, block_count
// m_out    | source    | mosi_byte, select_low, data_valid, data_byte, block_end, done_res, status
// Each transaction passes through the combinational state logic into the result register.
// A new transaction is taken every cycle while the result register is empty or drained.
// When m_out stalls, s_in is held off until the waiting result is taken.
// Synchronous active-low reset returns to idle with the default limits.
module sd_spi_host_sequencer_core #(
    parameter int BLOCK_BYTES = 512,
    parameter int RESPONSE_WAIT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    sds_stream_if.sink   s_in,
    sds_stream_if.source m_out
);
    import sds_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_cnt, n_cnt, r_retry, n_retry, r_tok_lim, r_ret_lim;
    logic [47:0] r_frame, n_frame;
    logic [31:0] r_cap, n_cap;
    logic        r_hc, n_hc, r_valid;
    logic [7:0]  r_blocks, n_blocks;
    t_out_item   r_res, n_res;
    logic        acc;

    assign s_in.ready = !r_valid || m_out.ready;
    assign acc = s_in.valid && s_in.ready;
    assign m_out.valid = r_valid;
    assign m_out.data = r_res;

    sds_engine #(.BLOCK_BYTES(BLOCK_BYTES), .RESPONSE_WAIT(RESPONSE_WAIT)) u_engine (
        .i_item(s_in.data), .i_phase(r_phase), .i_cnt(r_cnt), .i_retry(r_retry),
        .i_frame(r_frame), .i_cap(r_cap), .i_hc(r_hc), .i_blocks(r_blocks),
        .i_tok_lim(r_tok_lim), .i_ret_lim(r_ret_lim),
        .o_phase(n_phase), .o_cnt(n_cnt), .o_retry(n_retry), .o_frame(n_frame),
        .o_cap(n_cap), .o_hc(n_hc), .o_blocks(n_blocks), .o_res(n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt <= '0;
            r_retry <= '0;
            r_frame <= '0;
            r_cap <= '0;
            r_hc <= 1'b0;
            r_blocks <= '0;
            r_valid <= 1'b0;
            r_tok_lim <= 16'd50000;
            r_ret_lim <= 16'd1000;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TOKEN_LIMIT) r_tok_lim <= i_cfg_data;
                if (i_cfg_index == CFG_RETRY_LIMIT) r_ret_lim <= i_cfg_data;
            end
            if (acc) begin
                r_phase <= n_phase;
                r_cnt <= n_cnt;
                r_retry <= n_retry;
                r_frame <= n_frame;
                r_cap <= n_cap;
                r_hc <= n_hc;
                r_blocks <= n_blocks;
                r_valid <= 1'b1;
            end else if (m_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_res <= n_res;
    end
endmodule

// ===== rtl/core/sds_checker.sv =====
// Port-level checker for the SD SPI sequencer, bound to the top level.
`include "sd_spi_host_sequencer_core_macros.svh"
module sds_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input sds_pkg::t_out_item out_data
);
    `SDS_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_valid && in_ready, out_valid)
    `SDS_ASSERT_IMPL(a_stall_blocks, i_clk, i_rst_n, out_valid && !out_ready, !in_ready)
    `SDS_ASSERT_IMPL(a_done_cs_high, i_clk, i_rst_n, out_valid && out_data.done_res, !out_data.select_low && !out_data.data_valid)
    `SDS_ASSERT_IMPL(a_status_quiet, i_clk, i_rst_n, out_valid && !out_data.done_res, out_data.status == 4'd0)
endmodule

bind sd_spi_host_sequencer_core sds_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready), .out_data(m_out.data)
);

// ===== sim/sd_spi_host_sequencer_core_tb.sv =====
// Self-checking testbench for the SD SPI-mode host sequencer with a card-aware stimulus.
module sd_spi_host_sequencer_core_tb;
    import sds_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = CFG_TOKEN_LIMIT;
    logic [15:0] i_cfg_data = 16'd0;

    sds_stream_if #(.T(t_in_item))  in_ch ();
    sds_stream_if #(.T(t_out_item)) out_ch ();

    sd_spi_host_sequencer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_in        (in_ch.sink),
        .m_out       (out_ch.source)
    );

    initial in_ch.valid = 1'b0;
    initial in_ch.data = '0;
    initial out_ch.ready = 1'b0;

    always #5 i_clk = ~i_clk;

    // Host state as the card would see it.
    t_phase      host_phase;
    logic [15:0] host_count;
    logic [15:0] acmd_tries;
    logic [47:0] cmd_frame;
    logic [31:0] reply_word;
    logic        card_hc;
    logic [7:0]  blocks_left;
    logic [15:0] token_limit;
    logic [15:0] retry_limit;
    t_out_item   exch;

    t_in_item  pending_items[$];
    t_out_item expected_exch[$];
    t_in_item  request_plan[$];
    int        src_idle_pct = 0;
    int        snk_stall_pct = 0;
    int        hold_trig = 0;
    int        hold_seen = 0;
    int        hold_cycles = 0;
    bit        failed = 1'b0;
    bit        card_sends_data = 1'b0;

    function automatic logic [5:0] frame_cmd();
        return cmd_frame[45:40];
    endfunction

    task automatic send_idle(input logic sel);
        exch.mosi_byte = BYTE_IDLE;
        exch.select_low = sel;
    endtask

    task automatic load_cmd(input logic [5:0] cmd, input logic [31:0] arg, input logic [7:0] crc);
        cmd_frame = {2'b01, cmd, arg, crc};
    endtask

    task automatic begin_cmd(input logic [5:0] cmd, input logic [31:0] arg,
                             input logic [7:0] crc, input logic sel, input logic [15:0] pos);
        load_cmd(cmd, arg, crc);
        send_idle(sel);
        host_phase = PH_CMD;
        host_count = pos;
    endtask

    task automatic finish_req(input logic [3:0] code);
        send_idle(1'b0);
        exch.done_res = 1'b1;
        exch.status = code;
        host_phase = PH_IDLE;
    endtask

    task automatic wait_on(input t_phase next);
        send_idle(1'b1);
        host_phase = next;
        host_count = 16'd0;
    endtask

    task automatic next_acmd();
        if (acmd_tries < retry_limit) begin
            acmd_tries++;
            begin_cmd(CMD_APP, 32'd0, 8'h65, 1'b0, 16'd2);
        end else begin
            finish_req(ST_ACMD41);
        end
    endtask

    task automatic stop_read(input logic [31:0] code);
        reply_word = code;
        begin_cmd(CMD_STOP, 32'd0, 8'h01, 1'b1, 16'd3);
    endtask

    task automatic handle_r1(input logic [7:0] r);
        case (frame_cmd())
            CMD_GO_IDLE: begin
                if (r == 8'h01) begin_cmd(CMD_IF_COND, 32'h1AA, 8'h87, 1'b1, 16'd3);
                else finish_req(ST_CMD0);
            end
            CMD_IF_COND: begin
                if (r == 8'h01) begin
                    reply_word = '0;
                    wait_on(PH_TAIL);
                end else finish_req(ST_CMD8);
            end
            CMD_APP: begin_cmd(CMD_OP_COND, 32'h4000_0000, 8'h01, 1'b1, 16'd1);
            CMD_OP_COND: begin
                if (r == 8'h01) next_acmd();
                else if (r == 8'h00) begin_cmd(CMD_READ_OCR, 32'd0, 8'h01, 1'b1, 16'd3);
                else finish_req(ST_ACMD41);
            end
            CMD_READ_OCR: begin
                if (r == 8'h00) begin
                    reply_word = '0;
                    wait_on(PH_TAIL);
                end else finish_req(ST_CMD58);
            end
            CMD_BLOCKLEN: finish_req(r == 8'h00 ? ST_OK : ST_CMD16);
            CMD_READ_ONE: begin
                if (r == 8'h00) wait_on(PH_TOKEN);
                else finish_req(ST_READ);
            end
            CMD_READ_MULTI: begin
                if (r != 8'h00) finish_req(ST_READ);
                else if (blocks_left == 0) stop_read(32'd0);
                else wait_on(PH_TOKEN);
            end
            CMD_STOP: wait_on(PH_BUSY);
            default: finish_req(ST_OK);
        endcase
    endtask

    task automatic step_host(input t_in_item it, output t_out_item res);
        logic [15:0] p;
        logic [16:0] n;
        exch = '0;
        exch.mosi_byte = BYTE_IDLE;
        n = {1'b0, host_count} + 17'd1;
        case (host_phase)
            PH_WAKE: begin
                send_idle(1'b0);
                if (n >= 17'd11) begin
                    load_cmd(CMD_GO_IDLE, 32'd0, 8'h95);
                    host_phase = PH_CMD;
                    host_count = 16'd2;
                end else host_count = n[15:0];
            end
            PH_CMD: begin
                p = host_count > 16'd8 ? 16'd8 : host_count;
                exch.select_low = 1'b1;
                if (p >= 16'd3) exch.mosi_byte = 8'(cmd_frame >> (8 * (8 - p)));
                if (p >= 16'd8) begin
                    host_phase = PH_R1;
                    host_count = 16'd0;
                end else host_count = p + 16'd1;
            end
            PH_R1: begin
                if (host_count == 16'd0) begin
                    send_idle(1'b1);
                    host_count = 16'd1;
                end else if (it.miso_byte != BYTE_IDLE) handle_r1(it.miso_byte);
                else if (host_count >= 16'd8) handle_r1(BYTE_IDLE);
                else begin
                    send_idle(1'b1);
                    host_count++;
                end
            end
            PH_TAIL: begin
                reply_word = {reply_word[23:0], it.miso_byte};
                host_count++;
                if (host_count < 16'd4) send_idle(1'b1);
                else if (frame_cmd() == CMD_IF_COND) begin
                    if (reply_word[15:0] == 16'h01AA) next_acmd();
                    else finish_req(ST_ECHO);
                end else begin
                    card_hc = reply_word[30];
                    if (card_hc) finish_req(ST_OK);
                    else begin_cmd(CMD_BLOCKLEN, 32'd512, 8'h01, 1'b0, 16'd2);
                end
            end
            PH_TOKEN: begin
                if (it.miso_byte == DATA_TOKEN) wait_on(PH_DATA);
                else if (n >= {1'b0, token_limit}) begin
                    if (frame_cmd() == CMD_READ_MULTI) stop_read(32'(ST_TOKEN));
                    else finish_req(ST_TOKEN);
                end else begin
                    host_count = n[15:0];
                    send_idle(1'b1);
                end
            end
            PH_DATA: begin
                exch.data_valid = 1'b1;
                exch.data_byte = it.miso_byte;
                if (n >= 17'd512) begin
                    exch.block_end = 1'b1;
                    wait_on(PH_CRC);
                end else begin
                    host_count = n[15:0];
                    send_idle(1'b1);
                end
            end
            PH_CRC: begin
                if (n < 17'd2) begin
                    host_count = n[15:0];
                    send_idle(1'b1);
                end else if (frame_cmd() == CMD_READ_MULTI) begin
                    if (blocks_left > 0) blocks_left--;
                    if (blocks_left > 0) wait_on(PH_TOKEN);
                    else stop_read(32'd0);
                end else finish_req(ST_OK);
            end
            PH_BUSY: begin
                if (it.miso_byte == BYTE_IDLE || n >= {1'b0, token_limit})
                    finish_req(reply_word[3:0]);
                else begin
                    host_count = n[15:0];
                    send_idle(1'b1);
                end
            end
            default: begin
                host_phase = PH_IDLE;
                if (it.kind == KIND_INIT) begin
                    acmd_tries = '0;
                    host_phase = PH_WAKE;
                    host_count = 16'd1;
                end else if (it.kind == KIND_READ_ONE || it.kind == KIND_READ_MULTI) begin
                    p = 16'd0;
                    if (it.kind == KIND_READ_MULTI) begin
                        blocks_left = it.block_count;
                        begin_cmd(CMD_READ_MULTI, card_hc ? it.block_address
                                  : {it.block_address[22:0], 9'd0}, 8'h01, 1'b1, 16'd3);
                    end else begin
                        begin_cmd(CMD_READ_ONE, card_hc ? it.block_address
                                  : {it.block_address[22:0], 9'd0}, 8'h01, 1'b1, 16'd3);
                    end
                end
            end
        endcase
        res = exch;
    endtask

    // Picks the byte a plausible card would return, with occasional garbage.
    function automatic logic [7:0] card_reply();
        int roll;
        roll = $urandom_range(99);
        case (host_phase)
            PH_R1: begin
                if (host_count == 16'd0 || roll < 15) return BYTE_IDLE;
                if (roll < 20) return 8'($urandom);
                case (frame_cmd())
                    CMD_GO_IDLE, CMD_IF_COND: return 8'h01;
                    CMD_OP_COND: return ($urandom_range(2) == 0) ? 8'h00 : 8'h01;
                    CMD_APP, CMD_STOP: return 8'($urandom);
                    default: return 8'h00;
                endcase
            end
            PH_TAIL: begin
                if (roll < 5) return 8'($urandom);
                if (frame_cmd() == CMD_IF_COND)
                    return (host_count == 16'd2) ? 8'h01 : (host_count == 16'd3) ? 8'hAA : 8'h00;
                return 8'($urandom);
            end
            PH_TOKEN: begin
                // Without data the card never sends the start token.
                if (!card_sends_data) return (roll < 90) ? BYTE_IDLE : 8'h00;
                return (roll < 70) ? DATA_TOKEN : (roll < 95) ? BYTE_IDLE : 8'($urandom);
            end
            PH_BUSY: return (roll < 50) ? BYTE_IDLE : 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_item(input t_in_item it);
        t_out_item res;
        step_host(it, res);
        pending_items.push_back(it);
        expected_exch.push_back(res);
    endtask

    task automatic random_request(output t_in_item it);
        int roll;
        roll = $urandom_range(99);
        it = {2'($urandom), 8'($urandom), 32'($urandom), 8'($urandom_range(0, 3))};
        if (roll < 30) it.kind = KIND_INIT;
        else if (roll < 60) it.kind = KIND_READ_ONE;
        else if (roll < 90) it.kind = KIND_READ_MULTI;
        else it.kind = KIND_BYTE;
    endtask

    // Runs requests until the given number of them have been issued and the last has finished.
    task automatic run_requests(input int num);
        t_in_item it;
        int issued;
        issued = 0;
        while (issued < num || host_phase != PH_IDLE) begin
            if (host_phase == PH_IDLE) begin
                if (issued >= num) break;
                if (request_plan.size() > 0) it = request_plan.pop_front();
                else random_request(it);
                if (it.kind != KIND_BYTE) issued++;
            end else begin
                it = {2'($urandom), 8'($urandom), 32'($urandom), 8'($urandom)};
                if ($urandom_range(99) >= 3) begin
                    it.kind = KIND_BYTE;
                    if ($urandom_range(99) >= 5) it.miso_byte = card_reply();
                end
            end
            queue_item(it);
        end
    endtask

    task automatic set_limits(input logic [15:0] tok, input logic [15:0] ret);
        while (pending_items.size() != 0 || expected_exch.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_TOKEN_LIMIT;
        i_cfg_data <= tok;
        @(posedge i_clk);
        i_cfg_index <= CFG_RETRY_LIMIT;
        i_cfg_data <= ret;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        token_limit = tok;
        retry_limit = ret;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                in_ch.data <= pending_items.pop_front();
                in_ch.valid <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_cycles <= 400;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        out_ch.ready <= i_rst_n && hold_cycles == 0 && $urandom_range(99) >= snk_stall_pct;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_exch.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, got %p", $time,
                         out_ch.data);
                failed = 1'b1;
            end else begin
                want = expected_exch.pop_front();
                if (out_ch.data.mosi_byte !== want.mosi_byte
                        || out_ch.data.select_low !== want.select_low
                        || out_ch.data.data_valid !== want.data_valid
                        || out_ch.data.data_byte !== want.data_byte
                        || out_ch.data.block_end !== want.block_end
                        || out_ch.data.done_res !== want.done_res
                        || out_ch.data.status !== want.status) begin
                    $display("%0t: mismatch, expected %p, got %p", $time, want, out_ch.data);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        host_phase = PH_IDLE;
        host_count = '0;
        acmd_tries = '0;
        cmd_frame = '0;
        reply_word = '0;
        card_hc = 1'b0;
        blocks_left = '0;
        token_limit = 16'd50000;
        retry_limit = 16'd1000;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A read before init at the top address with a zero block count, init, one full block.
        card_sends_data = 1'b1;
        request_plan.push_back({KIND_READ_MULTI, 8'hFF, 32'hFFFF_FFFF, 8'd0});
        request_plan.push_back({KIND_INIT, 8'h00, 32'h0, 8'd0});
        request_plan.push_back({KIND_READ_ONE, 8'h00, 32'hFFFF_FFFF, 8'd1});
        run_requests(3);

        set_limits(16'd1, 16'd1);
        card_sends_data = 1'b0;
        src_idle_pct = 55;
        run_requests(2);

        set_limits(16'd3, 16'd2);
        src_idle_pct = 0;
        snk_stall_pct = 55;
        run_requests(2);

        set_limits(16'd2, 16'd3);
        src_idle_pct = 31;
        snk_stall_pct = 31;
        request_plan.push_back({KIND_INIT, 8'h00, 32'h0, 8'd0});
        request_plan.push_back({KIND_READ_MULTI, 8'h00, 32'h8000_0001, 8'd2});
        run_requests(2);

        set_limits(16'd50000, 16'd1000);
        src_idle_pct = 0;
        snk_stall_pct = 0;
        request_plan.push_back({KIND_READ_MULTI, 8'h00, 32'h0000_0003, 8'd0});
        run_requests(1);
        hold_trig = hold_trig + 1;
        request_plan.push_back({KIND_READ_MULTI, 8'h00, 32'h0000_0007, 8'd0});
        run_requests(1);

        while (expected_exch.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failed) begin
            $display("[FAIL] regression broken");
        end else begin
            $display("[ OK ] regression clean");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/sds_pkg.sv
rtl/core/sds_stream_if.sv
rtl/core/sds_engine.sv
rtl/core/sd_spi_host_sequencer_core.sv
rtl/core/sds_checker.sv
sim/sd_spi_host_sequencer_core_tb.sv
